### hw/rtl/srt_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
package srt_pkg;

    localparam int IDX_W   = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int PROC_W  = 4;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Search token handed from cell to cell during a tick
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [BURST_W-1:0] best;
        logic [IDX_W-1:0]   idx;
        logic               any_big;
        logic               one_seen;
        logic               two_ones;
    } token_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [ARR_W-1:0]   wr_arrival;
        logic [BURST_W-1:0] wr_burst;
        logic               dec_en;
        logic [IDX_W-1:0]   dec_idx;
        logic [TIME_W-1:0]  now;
    } ctl_t;

endpackage

### hw/rtl/srt_cell.sv
// One table slot: holds a process entry and folds it into the passing search token.
module srt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  srt_pkg::ctl_t   ctl,
    input  srt_pkg::token_t tok_in,
    output srt_pkg::token_t tok_out
);

    localparam int IdxW   = srt_pkg::IDX_W;
    localparam int ArrW   = srt_pkg::ARR_W;
    localparam int BurstW = srt_pkg::BURST_W;
    localparam int TimeW  = srt_pkg::TIME_W;

    logic              loaded_reg;
    logic [ArrW-1:0]   arr_reg;
    logic [BurstW-1:0] rem_reg;
    srt_pkg::token_t   tok_reg;
    srt_pkg::token_t   tok_next;

    logic my_wr;
    logic my_dec;
    logic arrived;
    logic has_work;
    logic eligible;
    logic better;

    assign my_wr  = ctl.wr_en && (ctl.wr_idx == IdxW'(CELL_IDX));
    assign my_dec = ctl.dec_en && (ctl.dec_idx == IdxW'(CELL_IDX));

    // Arrived when arrival is not later than the current time
    assign arrived  = (ctl.now[TimeW-1:ArrW] != '0) || (arr_reg <= ctl.now[ArrW-1:0]);
    assign has_work = loaded_reg && (rem_reg != '0);
    assign eligible = has_work && arrived;
    assign better   = eligible && (!tok_in.found || (rem_reg < tok_in.best));

    // Fold this entry into the token
    always_comb
    begin
        tok_next          = tok_in;
        tok_next.found    = tok_in.found || eligible;
        if (better)
        begin
            tok_next.best = rem_reg;
            tok_next.idx  = IdxW'(CELL_IDX);
        end
        tok_next.any_big  = tok_in.any_big || (has_work && (rem_reg != BurstW'(1)));
        tok_next.one_seen = tok_in.one_seen || (loaded_reg && (rem_reg == BurstW'(1)));
        tok_next.two_ones = tok_in.two_ones
                            || (tok_in.one_seen && loaded_reg && (rem_reg == BurstW'(1)));
    end

    // Hand the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (my_wr)
            begin
                loaded_reg <= 1'b1;
            end
        end
    end

    // Load and decrement the entry
    always_ff @(posedge clk)
    begin
        if (my_wr)
        begin
            arr_reg <= ctl.wr_arrival;
            rem_reg <= ctl.wr_burst;
        end
        else if (my_dec)
        begin
            rem_reg <= rem_reg - BurstW'(1);
        end
    end

    assign tok_out = tok_reg;

endmodule

### hw/rtl/shortest_remaining_time_tick.sv
// Preemptive shortest-remaining-time scheduler: sequencer and chain of table cells.
//
// Input channel (in_valid / in_stall) carries one word per item: func selects
// a load (append arrival/burst to the process table) or a tick (serve one
// time unit). Output channel (out_valid / out_stall) returns one word per item.
// A load goes from acceptance to the finish state; there out_valid rises and the
// input is freed together once the output register is free. A tick sends a
// search token down the row of MAX_PROCESSES cells, one cell per cycle, then
// applies the decrement and moves on to the finish state, which ends it alike.
// One item is in work at a time; in_stall is high from acceptance until the
// result moves into the output register. The next item is taken while that
// result still waits for the receiver.
// When out_stall holds the output word, the finished result waits in the
// sequencer and in_stall stays high until the output register frees up.
// Reset empties the table and clears the time counter; no clearing pass is
// needed, entries become valid as they are loaded.
module shortest_remaining_time_tick #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [srt_pkg::ARR_W-1:0]    arrival,
    input  logic [srt_pkg::BURST_W-1:0]  burst,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ran,
    output logic [srt_pkg::PROC_W-1:0]   process,
    output logic [srt_pkg::TIME_W-1:0]   slot_start,
    output logic                         process_done,
    output logic                         all_done,
    output logic                         load_rejected
);

    localparam int CntW   = $clog2(MAX_PROCESSES + 1);
    localparam int IdxW   = srt_pkg::IDX_W;
    localparam int BurstW = srt_pkg::BURST_W;
    localparam int TimeW  = srt_pkg::TIME_W;
    localparam int ProcW  = srt_pkg::PROC_W;

    srt_pkg::state_t   state_reg, state_next;
    logic [CntW-1:0]   entry_count_reg, entry_count_next;
    logic [TimeW-1:0]  time_reg, time_next;
    logic              all_done_reg, all_done_next;

    logic              res_ran_reg, res_ran_next;
    logic [ProcW-1:0]  res_proc_reg, res_proc_next;
    logic [TimeW-1:0]  res_start_reg, res_start_next;
    logic              res_pdone_reg, res_pdone_next;
    logic              res_rej_reg, res_rej_next;

    logic              out_valid_reg, out_valid_next;
    logic              ran_reg, ran_next;
    logic [ProcW-1:0]  proc_reg, proc_next;
    logic [TimeW-1:0]  start_reg, start_next;
    logic              pdone_reg, pdone_next;
    logic              alldone_reg, alldone_next;
    logic              rej_reg, rej_next;

    srt_pkg::ctl_t     ctl;
    srt_pkg::token_t   tok [MAX_PROCESSES+1];
    srt_pkg::token_t   tail;
    logic              picked_one;

    // Row of cells, token enters at cell 0
    for (genvar g = 0; g < MAX_PROCESSES; g++)
    begin : g_cell
        srt_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tail       = tok[MAX_PROCESSES];
    assign picked_one = tail.found && (tail.best == BurstW'(1));

    // Sequencer: next state, broadcast control and result capture
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        time_next        = time_reg;
        all_done_next    = all_done_reg;
        res_ran_next     = res_ran_reg;
        res_proc_next    = res_proc_reg;
        res_start_next   = res_start_reg;
        res_pdone_next   = res_pdone_reg;
        res_rej_next     = res_rej_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ran_next         = ran_reg;
        proc_next        = proc_reg;
        start_next       = start_reg;
        pdone_next       = pdone_reg;
        alldone_next     = alldone_reg;
        rej_next         = rej_reg;
        in_stall         = 1'b1;
        ctl              = '0;
        ctl.now          = time_reg;
        tok[0]           = '0;

        case (state_reg)
            srt_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (func == srt_pkg::FUNC_LOAD)
                    begin
                        res_ran_next   = 1'b0;
                        res_proc_next  = '0;
                        res_start_next = '0;
                        res_pdone_next = 1'b0;
                        if (entry_count_reg < CntW'(MAX_PROCESSES))
                        begin
                            ctl.wr_en        = 1'b1;
                            ctl.wr_idx       = IdxW'(entry_count_reg);
                            ctl.wr_arrival   = arrival;
                            ctl.wr_burst     = burst;
                            entry_count_next = entry_count_reg + CntW'(1);
                            all_done_next    = all_done_reg && (burst == '0);
                            res_rej_next     = 1'b0;
                        end
                        else
                        begin
                            res_rej_next = 1'b1;
                        end
                        state_next = srt_pkg::S_FINISH;
                    end
                    else
                    begin
                        tok[0].valid = 1'b1;
                        state_next   = srt_pkg::S_SCAN;
                    end
                end
            end

            srt_pkg::S_SCAN:
            begin
                if (tail.valid)
                begin
                    res_start_next = time_reg;
                    res_ran_next   = tail.found;
                    res_proc_next  = tail.found ? tail.idx[ProcW-1:0] : '0;
                    res_pdone_next = picked_one;
                    res_rej_next   = 1'b0;
                    ctl.dec_en     = tail.found;
                    ctl.dec_idx    = tail.idx;
                    all_done_next  = !tail.any_big
                                     && (!tail.one_seen || (!tail.two_ones && picked_one));
                    if (time_reg != '1)
                    begin
                        time_next = time_reg + TimeW'(1);
                    end
                    state_next = srt_pkg::S_FINISH;
                end
            end

            srt_pkg::S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ran_next       = res_ran_reg;
                    proc_next      = res_proc_reg;
                    start_next     = res_start_reg;
                    pdone_next     = res_pdone_reg;
                    alldone_next   = all_done_reg;
                    rej_next       = res_rej_reg;
                    state_next     = srt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = srt_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= srt_pkg::S_IDLE;
            entry_count_reg <= '0;
            time_reg        <= '0;
            all_done_reg    <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            time_reg        <= time_next;
            all_done_reg    <= all_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        res_ran_reg   <= res_ran_next;
        res_proc_reg  <= res_proc_next;
        res_start_reg <= res_start_next;
        res_pdone_reg <= res_pdone_next;
        res_rej_reg   <= res_rej_next;
        ran_reg       <= ran_next;
        proc_reg      <= proc_next;
        start_reg     <= start_next;
        pdone_reg     <= pdone_next;
        alldone_reg   <= alldone_next;
        rej_reg       <= rej_next;
    end

    assign out_valid     = out_valid_reg;
    assign ran           = ran_reg;
    assign process       = proc_reg;
    assign slot_start    = start_reg;
    assign process_done  = pdone_reg;
    assign all_done      = alldone_reg;
    assign load_rejected = rej_reg;

    // A new output word comes only from the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == srt_pkg::S_FINISH))
        else $error("output word raised outside finish step");

    // The token only leaves the row while a tick is being scanned
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == srt_pkg::S_SCAN))
        else $error("search token emerged outside scan");

    // The table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CntW'(MAX_PROCESSES))
        else $error("entry count beyond table size");

    // A finished process implies a served slot, and a served slot is never a rejected load
    a_done_needs_ran: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (pdone_reg || rej_reg) |-> (ran_reg == pdone_reg || !rej_reg)
                                                    && !(pdone_reg && !ran_reg)
                                                    && !(ran_reg && rej_reg))
        else $error("inconsistent result flags");

    // A tick always advances time unless saturated
    a_time_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srt_pkg::S_SCAN) && tail.valid && (time_reg != '1)
        |=> time_reg == $past(time_reg) + TimeW'(1))
        else $error("time did not advance on tick");

endmodule
